FILE: rtl/core/point_charge_field_jacobian_unit_assert.svh
// Assertion macros for the point charge field Jacobian unit.
// Plain concurrent property wrappers; no dependencies.
`ifndef POINT_CHARGE_FIELD_JACOBIAN_UNIT_ASSERT_SVH
`define POINT_CHARGE_FIELD_JACOBIAN_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCFJ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCFJ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/pcfj_pkg.sv
// Types, register codes and arithmetic helpers of the point charge field unit.
// No dependencies.
`default_nettype none

package pcfj_pkg;

   localparam int EXP_W = 10;

   typedef enum logic [1:0] {
      CSR_CHARGE_X     = 2'b00,
      CSR_CHARGE_Y     = 2'b01,
      CSR_CHARGE_VALUE = 2'b10,
      CSR_PLANE_HEIGHT = 2'b11
   } csr_idx_type;

   typedef logic signed [EXP_W-1:0] exp_type;

   // Mantissa below 2^32 times a power of two.
   typedef struct packed {
      logic [31:0] m;
      exp_type     e;
   } bf_type;

   // Full product before it is normalized.
   typedef struct packed {
      logic [63:0] p;
      exp_type     e;
   } prod_type;

   typedef struct packed {
      logic [31:0] mag;
      logic        over;
      logic        neg;
   } emit_type;

   typedef struct packed {
      logic              sing;
      logic              dxn;
      logic              dyn;
      logic signed [5:0] s;
   } tag_type;

   typedef struct packed {
      tag_type     tag;
      logic [29:0] ax;
      logic [29:0] ay;
      logic [59:0] axay;
      logic        xxn;
      logic [61:0] xxm;
      logic        yyn;
      logic [61:0] yym;
   } side_type;

   function automatic prod_type bf_mul(input bf_type a, input bf_type b);
      prod_type r;
      r.p = 64'(a.m) * 64'(b.m);
      r.e = a.e + b.e;
      return r;
   endfunction

   // Drop low bits until the mantissa fits in 32 bits.
   function automatic bf_type bf_nrm(input prod_type x);
      bf_type     r;
      logic [5:0] sh;
      sh = '0;
      for (int i = 0; i < 32; i++) begin
         if (x.p[32+i]) sh = 6'(i + 1);
      end
      r.m = 32'(x.p >> sh);
      r.e = x.e + exp_type'({4'b0000, sh});
      return r;
   endfunction

   // Scale to an integer magnitude and flag values past the signed limit.
   function automatic emit_type bf_emit(input bf_type v, input exp_type eo, input logic neg);
      emit_type    r;
      exp_type     e;
      exp_type     ne;
      logic [31:0] lim;
      logic [62:0] wide;
      e      = v.e + eo;
      ne     = -e;
      lim    = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      wide   = '0;
      r.neg  = neg;
      r.over = 1'b0;
      r.mag  = '0;
      if (v.m != '0) begin
         if (e >= exp_type'(32)) begin
            r.over = 1'b1;
         end else if (e >= exp_type'(0)) begin
            wide = 63'(v.m) << e[4:0];
            if (wide > 63'(lim)) r.over = 1'b1;
            else r.mag = wide[31:0];
         end else if (ne < exp_type'(32)) begin
            r.mag = v.m >> ne[4:0];
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] bf_out(input emit_type x);
      logic [31:0] v;
      v = x.over ? (x.neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : x.mag;
      return x.neg ? 32'(-v) : v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/point_charge_field_jacobian_unit.sv
// Point charge field and field Jacobian, fully pipelined.
// Depends on pcfj_pkg and point_charge_field_jacobian_unit_assert.svh.
`default_nettype none
`include "point_charge_field_jacobian_unit_assert.svh"

// The unit takes one target point per beat and returns the in-plane field of
// the configured point charge and the symmetric Jacobian of that field, all in
// signed fixed point with FRAC_BITS fraction bits. It takes a new beat in every
// cycle while the result side is ready. The pipeline depth is set by the
// 32-stage square root (one result bit per stage) and the 35-stage reciprocal
// divider (one quotient bit per stage), plus six stages in front for offsets,
// scaling and squares, and eleven behind for the floating products, scaling and
// saturation. When a result beat is not taken, the whole pipeline
// holds and no input beat is taken, so nothing is dropped or repeated. Values
// beyond the 32-bit range are clamped and flagged on rsp_saturated; a target
// exactly on the charge with zero plane height returns zeros and rsp_singular.
// Registers may be written only while no beat is in flight; the register port
// is always ready.
module point_charge_field_jacobian_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_field_x,
   output logic signed [31:0] rsp_field_y,
   output logic signed [31:0] rsp_grad_xx,
   output logic signed [31:0] rsp_grad_xy,
   output logic signed [31:0] rsp_grad_yy,
   output logic               rsp_saturated,
   output logic               rsp_singular,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int FRONT_N = 6;
   localparam int SQ_N    = 32;
   localparam int DV_N    = 35;
   localparam int CHAIN_N = 9;
   localparam int DEPTH   = FRONT_N + SQ_N + DV_N + CHAIN_N + 2;
   localparam int SIDE_N  = SQ_N + DV_N;

   // Register file.
   logic [31:0] cx_ff, cy_ff, cq_ff;
   logic [30:0] ch_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cq_ff <= '0;
         ch_ff <= 31'(1 << FRAC_BITS);
      end else if (csr_valid) begin
         unique case (pcfj_pkg::csr_idx_type'(csr_index))
            pcfj_pkg::CSR_CHARGE_X:     cx_ff <= csr_data;
            pcfj_pkg::CSR_CHARGE_Y:     cy_ff <= csr_data;
            pcfj_pkg::CSR_CHARGE_VALUE: cq_ff <= csr_data;
            pcfj_pkg::CSR_PLANE_HEIGHT: ch_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: every stage moves together unless the output is held.
   logic             adv;
   logic [DEPTH-1:0] vld_ff, vld_in;

   assign adv       = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid & adv};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Front: offsets, magnitudes, common scale, squares.
   logic [32:0]        d1x_ff, d1y_ff;
   logic [32:0]        m2x_ff, m2y_ff, m2h_ff, m2max_ff;
   logic [32:0]        m2x_in, m2y_in, m2h_in, m2max_in;
   logic               s2xn_ff, s2yn_ff;
   logic [32:0]        m3x_ff, m3y_ff, m3h_ff;
   logic [5:0]         lead_in;
   pcfj_pkg::tag_type  t3_ff, t4_ff, t5_ff, t6_ff;
   logic [5:0]         nsh;
   logic [29:0]        a4x_ff, a4y_ff, a4h_ff;
   logic [29:0]        a4x_in, a4y_in, a4h_in;
   logic [59:0]        q5x_ff, q5y_ff, q5h_ff, q5xy_ff;
   logic [29:0]        a5x_ff, a5y_ff;
   logic [61:0]        s6_sum_ff;
   logic [62:0]        s6_nxx_ff, s6_nyy_ff;
   logic [59:0]        s6_xy_ff;
   logic [29:0]        a6x_ff, a6y_ff;

   always_comb begin
      m2x_in   = d1x_ff[32] ? 33'(-d1x_ff) : d1x_ff;
      m2y_in   = d1y_ff[32] ? 33'(-d1y_ff) : d1y_ff;
      m2h_in   = {2'b00, ch_ff};
      m2max_in = m2x_in;
      if (m2y_in > m2max_in) m2max_in = m2y_in;
      if (m2h_in > m2max_in) m2max_in = m2h_in;
   end

   always_comb begin
      lead_in = '0;
      for (int i = 0; i < 33; i++) begin
         if (m2max_ff[i]) lead_in = 6'(i);
      end
   end

   // Scale so that the largest magnitude lands in [2^29, 2^30).
   always_comb begin
      nsh = 6'(-t3_ff.s);
      if (t3_ff.s[5]) begin
         a4x_in = 30'(m3x_ff >> nsh);
         a4y_in = 30'(m3y_ff >> nsh);
         a4h_in = 30'(m3h_ff >> nsh);
      end else begin
         a4x_in = 30'(m3x_ff << t3_ff.s[4:0]);
         a4y_in = 30'(m3y_ff << t3_ff.s[4:0]);
         a4h_in = 30'(m3h_ff << t3_ff.s[4:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1x_ff    <= {req_target_x[31], req_target_x} - {cx_ff[31], cx_ff};
         d1y_ff    <= {req_target_y[31], req_target_y} - {cy_ff[31], cy_ff};
         m2x_ff    <= m2x_in;
         m2y_ff    <= m2y_in;
         m2h_ff    <= m2h_in;
         m2max_ff  <= m2max_in;
         s2xn_ff   <= d1x_ff[32];
         s2yn_ff   <= d1y_ff[32];
         m3x_ff    <= m2x_ff;
         m3y_ff    <= m2y_ff;
         m3h_ff    <= m2h_ff;
         t3_ff     <= '{sing: (m2max_ff == '0), dxn: s2xn_ff, dyn: s2yn_ff,
                        s: 6'(6'd29 - lead_in)};
         a4x_ff    <= a4x_in;
         a4y_ff    <= a4y_in;
         a4h_ff    <= a4h_in;
         t4_ff     <= t3_ff;
         q5x_ff    <= 60'(a4x_ff) * 60'(a4x_ff);
         q5y_ff    <= 60'(a4y_ff) * 60'(a4y_ff);
         q5h_ff    <= 60'(a4h_ff) * 60'(a4h_ff);
         q5xy_ff   <= 60'(a4x_ff) * 60'(a4y_ff);
         a5x_ff    <= a4x_ff;
         a5y_ff    <= a4y_ff;
         t5_ff     <= t4_ff;
         s6_sum_ff <= 62'(q5x_ff) + 62'(q5y_ff) + 62'(q5h_ff);
         // sum - 3*x^2 is the same as y^2 + h^2 - 2*x^2.
         s6_nxx_ff <= 63'(q5y_ff) + 63'(q5h_ff) - {2'b00, q5x_ff, 1'b0};
         s6_nyy_ff <= 63'(q5x_ff) + 63'(q5h_ff) - {2'b00, q5y_ff, 1'b0};
         s6_xy_ff  <= q5xy_ff;
         a6x_ff    <= a5x_ff;
         a6y_ff    <= a5y_ff;
         t6_ff     <= t5_ff;
      end
   end

   // Side data that rides along the square root and the divider.
   pcfj_pkg::side_type side_ff [SIDE_N];
   pcfj_pkg::side_type side_in;

   always_comb begin
      side_in.tag  = t6_ff;
      side_in.ax   = a6x_ff;
      side_in.ay   = a6y_ff;
      side_in.axay = s6_xy_ff;
      side_in.xxn  = s6_nxx_ff[62];
      side_in.xxm  = 62'(s6_nxx_ff[62] ? 63'(-s6_nxx_ff) : s6_nxx_ff);
      side_in.yyn  = s6_nyy_ff[62];
      side_in.yym  = 62'(s6_nyy_ff[62] ? 63'(-s6_nyy_ff) : s6_nyy_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int j = 1; j < SIDE_N; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // Square root, one result bit per stage.
   logic [63:0] sqv_ff [SQ_N];
   logic [63:0] sqr_ff [SQ_N];
   logic [63:0] sqv_in [SQ_N];
   logic [63:0] sqr_in [SQ_N];

   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] src_v, src_r, trial;
      if (k == 0) begin : g_first
         assign src_v = {2'b00, s6_sum_ff};
         assign src_r = '0;
      end else begin : g_next
         assign src_v = sqv_ff[k-1];
         assign src_r = sqr_ff[k-1];
      end
      assign trial = src_r + SQ_BIT;
      always_comb begin
         if (src_v >= trial) begin
            sqv_in[k] = src_v - trial;
            sqr_in[k] = (src_r >> 1) + SQ_BIT;
         end else begin
            sqv_in[k] = src_v;
            sqr_in[k] = src_r >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQ_N; k++) begin
            sqv_ff[k] <= sqv_in[k];
            sqr_ff[k] <= sqr_in[k];
         end
      end
   end

   // Reciprocal 2^63 / R, one quotient bit per stage. R is at least 2^29, so
   // every quotient bit above bit 34 is zero and the remainder starts at 2^28.
   logic [31:0]   dvr_ff [DV_N];
   logic [31:0]   dvr_in [DV_N];
   logic [DV_N-1:0] dvq_ff [DV_N];
   logic [DV_N-1:0] dvq_in [DV_N];
   logic [30:0]   dvd_ff [DV_N];
   logic [30:0]   dvd_in [DV_N];

   for (genvar k = 0; k < DV_N; k++) begin : g_div
      logic [31:0]     src_rem;
      logic [DV_N-1:0] src_q;
      logic [30:0]     src_d;
      logic [32:0]     twice;
      if (k == 0) begin : g_first
         assign src_rem = 32'h1000_0000;
         assign src_q   = '0;
         assign src_d   = sqr_ff[SQ_N-1][30:0];
      end else begin : g_next
         assign src_rem = dvr_ff[k-1];
         assign src_q   = dvq_ff[k-1];
         assign src_d   = dvd_ff[k-1];
      end
      assign twice = {src_rem, 1'b0};
      always_comb begin
         dvd_in[k] = src_d;
         if (twice >= {2'b00, src_d}) begin
            dvr_in[k] = 32'(twice - {2'b00, src_d});
            dvq_in[k] = {src_q[DV_N-2:0], 1'b1};
         end else begin
            dvr_in[k] = twice[31:0];
            dvq_in[k] = {src_q[DV_N-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DV_N; k++) begin
            dvr_ff[k] <= dvr_in[k];
            dvq_ff[k] <= dvq_in[k];
            dvd_ff[k] <= dvd_in[k];
         end
      end
   end

   // Product chain: each multiply stage is followed by a normalize stage.
   pcfj_pkg::side_type sd_end;
   pcfj_pkg::bf_type   bq, three;
   logic               qn;
   pcfj_pkg::tag_type  tg_ff [CHAIN_N+1];

   assign sd_end = side_ff[SIDE_N-1];
   assign qn     = cq_ff[31];
   assign bq     = '{m: (qn ? 32'(-cq_ff) : cq_ff), e: '0};
   assign three  = '{m: 32'd3, e: '0};

   pcfj_pkg::bf_type   a_i1_ff, a_xx_ff, a_yy_ff, a_xy_ff, a_ax_ff, a_ay_ff;
   pcfj_pkg::prod_type b_p2_ff, b_qx_ff, b_qy_ff, b_xx_ff, b_yy_ff, b_xy_ff;
   pcfj_pkg::bf_type   b_i1_ff;
   pcfj_pkg::bf_type   c_i2_ff, c_qx_ff, c_qy_ff, c_xx_ff, c_yy_ff, c_xy_ff, c_i1_ff;
   pcfj_pkg::prod_type d_p3_ff, d_xy3_ff;
   pcfj_pkg::bf_type   d_i2_ff, d_qx_ff, d_qy_ff, d_xx_ff, d_yy_ff;
   pcfj_pkg::bf_type   e_i3_ff, e_xy3_ff, e_i2_ff, e_qx_ff, e_qy_ff, e_xx_ff, e_yy_ff;
   pcfj_pkg::prod_type f_p5_ff, f_fx_ff, f_fy_ff;
   pcfj_pkg::bf_type   f_xx_ff, f_yy_ff, f_xy3_ff;
   pcfj_pkg::bf_type   g_i5_ff, g_fx_ff, g_fy_ff, g_xx_ff, g_yy_ff, g_xy3_ff;
   pcfj_pkg::prod_type h_jxx_ff, h_jyy_ff, h_jxy_ff;
   pcfj_pkg::bf_type   h_fx_ff, h_fy_ff;
   pcfj_pkg::bf_type   i_jxx_ff, i_jyy_ff, i_jxy_ff, i_fx_ff, i_fy_ff;
   pcfj_pkg::emit_type j_fx_ff, j_fy_ff, j_xx_ff, j_xy_ff, j_yy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         tg_ff[0] <= sd_end.tag;
         for (int j = 1; j <= CHAIN_N; j++) begin
            tg_ff[j] <= tg_ff[j-1];
         end
         // A: bring the operands into mantissa form.
         a_i1_ff  <= pcfj_pkg::bf_nrm('{p: 64'(dvq_ff[DV_N-1]), e: '0});
         a_xx_ff  <= pcfj_pkg::bf_nrm('{p: 64'(sd_end.xxm), e: '0});
         a_yy_ff  <= pcfj_pkg::bf_nrm('{p: 64'(sd_end.yym), e: '0});
         a_xy_ff  <= pcfj_pkg::bf_nrm('{p: 64'(sd_end.axay), e: '0});
         a_ax_ff  <= '{m: 32'(sd_end.ax), e: '0};
         a_ay_ff  <= '{m: 32'(sd_end.ay), e: '0};
         // B
         b_p2_ff  <= pcfj_pkg::bf_mul(a_i1_ff, a_i1_ff);
         b_qx_ff  <= pcfj_pkg::bf_mul(bq, a_ax_ff);
         b_qy_ff  <= pcfj_pkg::bf_mul(bq, a_ay_ff);
         b_xx_ff  <= pcfj_pkg::bf_mul(bq, a_xx_ff);
         b_yy_ff  <= pcfj_pkg::bf_mul(bq, a_yy_ff);
         b_xy_ff  <= pcfj_pkg::bf_mul(bq, a_xy_ff);
         b_i1_ff  <= a_i1_ff;
         // C
         c_i2_ff  <= pcfj_pkg::bf_nrm(b_p2_ff);
         c_qx_ff  <= pcfj_pkg::bf_nrm(b_qx_ff);
         c_qy_ff  <= pcfj_pkg::bf_nrm(b_qy_ff);
         c_xx_ff  <= pcfj_pkg::bf_nrm(b_xx_ff);
         c_yy_ff  <= pcfj_pkg::bf_nrm(b_yy_ff);
         c_xy_ff  <= pcfj_pkg::bf_nrm(b_xy_ff);
         c_i1_ff  <= b_i1_ff;
         // D
         d_p3_ff  <= pcfj_pkg::bf_mul(c_i2_ff, c_i1_ff);
         d_xy3_ff <= pcfj_pkg::bf_mul(c_xy_ff, three);
         d_i2_ff  <= c_i2_ff;
         d_qx_ff  <= c_qx_ff;
         d_qy_ff  <= c_qy_ff;
         d_xx_ff  <= c_xx_ff;
         d_yy_ff  <= c_yy_ff;
         // E
         e_i3_ff  <= pcfj_pkg::bf_nrm(d_p3_ff);
         e_xy3_ff <= pcfj_pkg::bf_nrm(d_xy3_ff);
         e_i2_ff  <= d_i2_ff;
         e_qx_ff  <= d_qx_ff;
         e_qy_ff  <= d_qy_ff;
         e_xx_ff  <= d_xx_ff;
         e_yy_ff  <= d_yy_ff;
         // F
         f_p5_ff  <= pcfj_pkg::bf_mul(e_i3_ff, e_i2_ff);
         f_fx_ff  <= pcfj_pkg::bf_mul(e_qx_ff, e_i3_ff);
         f_fy_ff  <= pcfj_pkg::bf_mul(e_qy_ff, e_i3_ff);
         f_xx_ff  <= e_xx_ff;
         f_yy_ff  <= e_yy_ff;
         f_xy3_ff <= e_xy3_ff;
         // G
         g_i5_ff  <= pcfj_pkg::bf_nrm(f_p5_ff);
         g_fx_ff  <= pcfj_pkg::bf_nrm(f_fx_ff);
         g_fy_ff  <= pcfj_pkg::bf_nrm(f_fy_ff);
         g_xx_ff  <= f_xx_ff;
         g_yy_ff  <= f_yy_ff;
         g_xy3_ff <= f_xy3_ff;
         // H
         h_jxx_ff <= pcfj_pkg::bf_mul(g_xx_ff, g_i5_ff);
         h_jyy_ff <= pcfj_pkg::bf_mul(g_yy_ff, g_i5_ff);
         h_jxy_ff <= pcfj_pkg::bf_mul(g_xy3_ff, g_i5_ff);
         h_fx_ff  <= g_fx_ff;
         h_fy_ff  <= g_fy_ff;
         // I
         i_jxx_ff <= pcfj_pkg::bf_nrm(h_jxx_ff);
         i_jyy_ff <= pcfj_pkg::bf_nrm(h_jyy_ff);
         i_jxy_ff <= pcfj_pkg::bf_nrm(h_jxy_ff);
         i_fx_ff  <= h_fx_ff;
         i_fy_ff  <= h_fy_ff;
      end
   end

   // The Jacobian diagonal signs come from the sign of r^2 - 3*d^2, carried
   // alongside the product chain so that they reach the scaling stage with
   // their beat.
   logic               xxn_ff [CHAIN_N];
   logic               yyn_ff [CHAIN_N];

   always_ff @(posedge clock) begin
      if (adv) begin
         xxn_ff[0] <= sd_end.xxn;
         yyn_ff[0] <= sd_end.yyn;
         for (int j = 1; j < CHAIN_N; j++) begin
            xxn_ff[j] <= xxn_ff[j-1];
            yyn_ff[j] <= yyn_ff[j-1];
         end
      end
   end

   // J: apply the fixed-point scale, truncate and detect overflow. The sign
   // picks the limit, which is one higher for negative values.
   pcfj_pkg::exp_type sx, eo_f, eo_j;
   pcfj_pkg::tag_type tg_i;

   assign tg_i = tg_ff[CHAIN_N-1];
   assign sx   = pcfj_pkg::exp_type'({{4{tg_i.s[5]}}, tg_i.s});
   assign eo_f = pcfj_pkg::exp_type'(2 * FRAC_BITS - 189) + (sx <<< 1);
   assign eo_j = pcfj_pkg::exp_type'(3 * FRAC_BITS - 315) + sx + (sx <<< 1);

   always_ff @(posedge clock) begin
      if (adv) begin
         j_fx_ff <= pcfj_pkg::bf_emit(i_fx_ff, eo_f, qn ^ tg_i.dxn);
         j_fy_ff <= pcfj_pkg::bf_emit(i_fy_ff, eo_f, qn ^ tg_i.dyn);
         j_xx_ff <= pcfj_pkg::bf_emit(i_jxx_ff, eo_j, qn ^ xxn_ff[CHAIN_N-1]);
         j_xy_ff <= pcfj_pkg::bf_emit(i_jxy_ff, eo_j, !(qn ^ tg_i.dxn ^ tg_i.dyn));
         j_yy_ff <= pcfj_pkg::bf_emit(i_jyy_ff, eo_j, qn ^ yyn_ff[CHAIN_N-1]);
      end
   end

   // K: output register.
   logic [31:0] o_fx_ff, o_fy_ff, o_xx_ff, o_xy_ff, o_yy_ff;
   logic        o_sat_ff, o_sing_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (tg_ff[CHAIN_N].sing) begin
            o_fx_ff   <= '0;
            o_fy_ff   <= '0;
            o_xx_ff   <= '0;
            o_xy_ff   <= '0;
            o_yy_ff   <= '0;
            o_sat_ff  <= 1'b0;
            o_sing_ff <= 1'b1;
         end else begin
            o_fx_ff   <= pcfj_pkg::bf_out(j_fx_ff);
            o_fy_ff   <= pcfj_pkg::bf_out(j_fy_ff);
            o_xx_ff   <= pcfj_pkg::bf_out(j_xx_ff);
            o_xy_ff   <= pcfj_pkg::bf_out(j_xy_ff);
            o_yy_ff   <= pcfj_pkg::bf_out(j_yy_ff);
            o_sat_ff  <= j_fx_ff.over | j_fy_ff.over | j_xx_ff.over | j_xy_ff.over
                         | j_yy_ff.over;
            o_sing_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = vld_ff[DEPTH-1];
   assign rsp_field_x   = o_fx_ff;
   assign rsp_field_y   = o_fy_ff;
   assign rsp_grad_xx   = o_xx_ff;
   assign rsp_grad_xy   = o_xy_ff;
   assign rsp_grad_yy   = o_yy_ff;
   assign rsp_saturated = o_sat_ff;
   assign rsp_singular  = o_sing_ff;

   // Summaries of the result beat used by the checks below.
   logic rsp_all_zero, rsp_any_clamped;

   assign rsp_all_zero = (rsp_field_x == '0) && (rsp_field_y == '0) && (rsp_grad_xx == '0)
                         && (rsp_grad_xy == '0) && (rsp_grad_yy == '0);
   assign rsp_any_clamped = (rsp_field_x == 32'h7FFF_FFFF) || (rsp_field_x == 32'h8000_0000)
                            || (rsp_field_y == 32'h7FFF_FFFF) || (rsp_field_y == 32'h8000_0000)
                            || (rsp_grad_xx == 32'h7FFF_FFFF) || (rsp_grad_xx == 32'h8000_0000)
                            || (rsp_grad_xy == 32'h7FFF_FFFF) || (rsp_grad_xy == 32'h8000_0000)
                            || (rsp_grad_yy == 32'h7FFF_FFFF) || (rsp_grad_yy == 32'h8000_0000);

   `PCFJ_ASSERT_SAME(a_singular_zero, clock, reset, rsp_valid && rsp_singular, rsp_all_zero && !rsp_saturated, "singular beat carries nonzero data")
   `PCFJ_ASSERT_SAME(a_sat_clamped, clock, reset, rsp_valid && rsp_saturated, rsp_any_clamped, "saturated beat has no clamped value")
   `PCFJ_ASSERT_NEXT(a_last_stage_lands, clock, reset, adv && vld_ff[DEPTH-2], rsp_valid, "beat lost at the output register")

endmodule

`default_nettype wire

FILE: test/point_charge_field_jacobian_unit_test.sv
// Self-checking testbench of the point charge field Jacobian unit.
// Depends on pcfj_pkg and point_charge_field_jacobian_unit; predicts every result in place.
`timescale 1ns / 1ps

module point_charge_field_jacobian_unit_test;

   localparam int FRAC_BITS = 16;
   // The pipeline is 84 stages deep; settle time before register writes and at the end.
   localparam int SETTLE = 120;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } target_type;

   typedef struct {
      logic [31:0] fx;
      logic [31:0] fy;
      logic [31:0] gxx;
      logic [31:0] gxy;
      logic [31:0] gyy;
      logic        sat;
      logic        sing;
   } field_type;

   // Mantissa times a power of two, the way the unit carries its products.
   typedef struct {
      longint unsigned m;
      int              e;
   } scaled_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_target_x;
   logic signed [31:0] req_target_y;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_field_x;
   logic signed [31:0] rsp_field_y;
   logic signed [31:0] rsp_grad_xx;
   logic signed [31:0] rsp_grad_xy;
   logic signed [31:0] rsp_grad_yy;
   logic               rsp_saturated;
   logic               rsp_singular;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [31:0]        csr_data;

   point_charge_field_jacobian_unit #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_field_x(rsp_field_x), .rsp_field_y(rsp_field_y),
      .rsp_grad_xx(rsp_grad_xx), .rsp_grad_xy(rsp_grad_xy), .rsp_grad_yy(rsp_grad_yy),
      .rsp_saturated(rsp_saturated), .rsp_singular(rsp_singular),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the charge registers, updated on each accepted register beat.
   logic signed [31:0] charge_x_q;
   logic signed [31:0] charge_y_q;
   logic signed [31:0] charge_q;
   logic [30:0]        height_q;

   target_type targets_pending[$];
   field_type  fields_expected[$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_left;
   int mismatches;
   int cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Field predictor. Magnitudes are normalized so the largest of dx, dy and h
   // sits in [2^29, 2^30), then r and 1/r come from integer square root and
   // division, and every product is truncated back below 2^32.
   // ---------------------------------------------------------------------------
   function automatic scaled_type scaled_norm(longint unsigned m, int e);
      scaled_type r;
      r.m = m;
      r.e = e;
      while (r.m >= 64'h1_0000_0000) begin
         r.m = r.m >> 1;
         r.e++;
      end
      return r;
   endfunction

   function automatic scaled_type scaled_mul(scaled_type a, scaled_type b);
      return scaled_norm(a.m * b.m, a.e + b.e);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned bitv;
      r = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // Truncate to an integer, clamp to the signed 32-bit range and apply the sign.
   function automatic logic [31:0] clamp_out(scaled_type v, int eo, bit neg, inout bit sat);
      longint unsigned lim;
      longint unsigned mag;
      int              e;
      e = v.e + eo;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (v.m == 0) return 32'd0;
      if (e >= 32) mag = lim + 1;
      else if (e >= 0) mag = v.m << e;
      else if (e <= -64) mag = 0;
      else mag = v.m >> (-e);
      if (mag > lim) begin
         sat = 1'b1;
         mag = lim;
      end
      return neg ? 32'(-mag) : 32'(mag);
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic field_type field_at(logic signed [31:0] tx, logic signed [31:0] ty);
      field_type       f;
      longint          dx, dy, q, nxx, nyy;
      longint unsigned mx, my, mh, mm, ax, ay, ah, sum, r, inv;
      int              s, fe, je;
      bit              sat, qn;
      scaled_type      bq, i1, i2, i3, i5;
      dx = longint'(tx) - longint'(charge_x_q);
      dy = longint'(ty) - longint'(charge_y_q);
      q = longint'(charge_q);
      mx = magnitude(dx);
      my = magnitude(dy);
      mh = height_q;
      f = '{default: '0};
      sat = 1'b0;
      qn = q < 0;
      s = 0;
      mm = mx;
      if (my > mm) mm = my;
      if (mh > mm) mm = mh;
      // Target on the charge with the charge in the plane: no defined field.
      if (mm == 0) begin
         f.sing = 1'b1;
         return f;
      end
      while (mm >= 64'd1 << 30) begin
         mm = mm >> 1;
         s--;
      end
      while (mm < 64'd1 << 29) begin
         mm = mm << 1;
         s++;
      end
      ax = s >= 0 ? mx << s : mx >> (-s);
      ay = s >= 0 ? my << s : my >> (-s);
      ah = s >= 0 ? mh << s : mh >> (-s);
      sum = ax * ax + ay * ay + ah * ah;
      r = root_floor(sum);
      inv = 64'h8000_0000_0000_0000 / r;
      nxx = longint'(sum) - longint'(3 * ax * ax);
      nyy = longint'(sum) - longint'(3 * ay * ay);
      fe = 2 * FRAC_BITS + 2 * s - 189;
      je = 3 * FRAC_BITS + 3 * s - 315;
      bq = scaled_norm(magnitude(q), 0);
      i1 = scaled_norm(inv, 0);
      i2 = scaled_mul(i1, i1);
      i3 = scaled_mul(i2, i1);
      i5 = scaled_mul(i3, i2);
      f.fx = clamp_out(scaled_mul(scaled_mul(bq, scaled_norm(ax, 0)), i3), fe,
                       qn != (dx < 0), sat);
      f.fy = clamp_out(scaled_mul(scaled_mul(bq, scaled_norm(ay, 0)), i3), fe,
                       qn != (dy < 0), sat);
      f.gxx = clamp_out(scaled_mul(scaled_mul(bq, scaled_norm(magnitude(nxx), 0)), i5),
                        je, qn != (nxx < 0), sat);
      // The cross term carries an extra minus sign: it is negative when q*dx*dy > 0.
      f.gxy = clamp_out(scaled_mul(scaled_mul(scaled_mul(bq, scaled_norm(ax * ay, 0)),
                        scaled_norm(3, 0)), i5), je, !(qn != ((dx < 0) != (dy < 0))), sat);
      f.gyy = clamp_out(scaled_mul(scaled_mul(bq, scaled_norm(magnitude(nyy), 0)), i5),
                        je, qn != (nyy < 0), sat);
      f.sat = sat;
      return f;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver. Each accepted beat gets its prediction at the same edge,
   // so the order of expectations is the order of acceptance.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      target_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) fields_expected.push_back(field_at(req_target_x, req_target_y));
         if (targets_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            t = targets_pending.pop_front();
            req_valid <= 1'b1;
            req_target_x <= t.x;
            req_target_y <= t.y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor. The receiver stalls at random, and during a hold-off keeps
   // ready low for a long stretch so the pipeline fills and backs up the input.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      field_type got;
      field_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_field_x, rsp_field_y, rsp_grad_xx, rsp_grad_xy, rsp_grad_yy,
                    rsp_saturated, rsp_singular};
            if (fields_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("result beat with nothing expected: %p", got);
            end else begin
               want = fields_expected.pop_front();
               if (got.fx !== want.fx || got.fy !== want.fy || got.gxx !== want.gxx ||
                   got.gxy !== want.gxy || got.gyy !== want.gyy ||
                   got.sat !== want.sat || got.sing !== want.sing) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
               end
            end
         end
         if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(0, 99) >= recv_stall_pct;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // One register beat; the shadow copy changes at the accepting edge.
   task automatic csr_write(pcfj_pkg::csr_idx_type idx, logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pcfj_pkg::CSR_CHARGE_X: charge_x_q = data;
         pcfj_pkg::CSR_CHARGE_Y: charge_y_q = data;
         pcfj_pkg::CSR_CHARGE_VALUE: charge_q = data;
         pcfj_pkg::CSR_PLANE_HEIGHT: height_q = data[30:0];
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic charge_setup(logic [31:0] cx, logic [31:0] cy, logic [31:0] q,
                               logic [31:0] h);
      csr_write(pcfj_pkg::CSR_CHARGE_X, cx);
      csr_write(pcfj_pkg::CSR_CHARGE_Y, cy);
      csr_write(pcfj_pkg::CSR_CHARGE_VALUE, q);
      csr_write(pcfj_pkg::CSR_PLANE_HEIGHT, h);
   endtask

   // Wait for the pipeline to drain, then for the settle time so nothing is in flight.
   task automatic drain();
      do @(posedge clock);
      while (targets_pending.size() > 0 || req_valid || fields_expected.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic queue_target(logic [31:0] x, logic [31:0] y);
      targets_pending.push_back('{x, y});
   endtask

   // Random targets: mostly near the charge so the results carry many bits,
   // the rest anywhere in the plane.
   task automatic queue_random(int count);
      logic [31:0] span;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            queue_target($urandom, $urandom);
         end else begin
            span = 32'd1 << $urandom_range(0, 24);
            queue_target(charge_x_q + ($urandom % (2 * span)) - span,
                         charge_y_q + ($urandom % (2 * span)) - span);
         end
      end
   endtask

   task automatic random_charge();
      logic [31:0] q;
      logic [31:0] h;
      case ($urandom_range(0, 2))
         0: q = $urandom;
         1: q = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: q = 32'h1 << $urandom_range(0, 30);
      endcase
      case ($urandom_range(0, 3))
         0: h = 32'd0;
         1: h = $urandom;
         default: h = $urandom_range(0, 32'h0010_0000);
      endcase
      charge_setup($urandom, $urandom, q, h);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_target_x = '0;
      req_target_y = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = pcfj_pkg::CSR_CHARGE_X;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_left = 0;
      mismatches = 0;
      cycles = 0;
      charge_x_q = '0;
      charge_y_q = '0;
      charge_q = '0;
      height_q = 31'(1 << FRAC_BITS);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset values: zero charge, so every value is zero.
      queue_target(32'h0, 32'h0);
      queue_target(32'h7FFF_FFFF, 32'h8000_0000);
      drain();

      // Unit charge in the plane at the origin: the singular point, tiny
      // distances that saturate, and the axes where the cross term vanishes.
      charge_setup(32'h0, 32'h0, 32'h0001_0000, 32'h0);
      queue_target(32'h0, 32'h0);
      queue_target(32'h1, 32'h0);
      queue_target(32'h0, 32'hFFFF_FFFF);
      queue_target(32'h0001_0000, 32'h0001_0000);
      queue_target(32'hFFFF_0000, 32'h0002_0000);
      queue_target(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_target(32'h8000_0000, 32'h8000_0000);
      queue_target(32'h8000_0000, 32'h7FFF_FFFF);
      drain();

      // Extreme registers: widest offsets, largest charge and height.
      charge_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_target(32'h7FFF_FFFF, 32'h8000_0000);
      queue_target(32'h8000_0000, 32'h7FFF_FFFF);
      queue_target(32'h0, 32'h0);
      drain();

      // Most negative charge, tiny height: flipped signs and saturation on both ends.
      charge_setup(32'h0000_8000, 32'hFFFF_8000, 32'h8000_0000, 32'h1);
      queue_target(32'h0000_8000, 32'hFFFF_8000);
      queue_target(32'h0000_8001, 32'hFFFF_8000);
      queue_target(32'h0010_0000, 32'h0);
      queue_target(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_target(32'h8000_0000, 32'h8000_0000);
      drain();
      // A weak charge far away: components that truncate to zero.
      charge_setup(32'h0, 32'h0, 32'h1, 32'h0001_0000);
      queue_target(32'h4000_0000, 32'hC000_0000);
      queue_target(32'h0, 32'h0);
      drain();

      // Random part, one idling mode per group of phases. The first phase of
      // the no-idling group also holds the receiver off while beats keep coming,
      // with more beats than the pipeline holds so that the input backs up.
      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct = (mode == 1) ? 51 : (mode == 3) ? 35 : 0;
         recv_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 35 : 0;
         for (int ph = 0; ph < 5; ph++) begin
            random_charge();
            if (mode == 0 && ph == 0) hold_off_left = 400;
            queue_random((mode == 0 && ph == 0) ? 200 : 44);
            drain();
         end
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
